FILE: rtl/core/bti_pkg.sv
// Shared types and constants for the bilinear table interpolator.
// Used by bilinear_table_interp; depends on nothing else.
package bti_pkg;

    localparam int VAL_W     = 32;   // Q16.16 word
    localparam int IDX_W     = 8;    // entry index and interval index
    localparam int MODE_W    = 2;
    localparam int CFG_W     = 5;    // points-used registers
    localparam int CFG_IDX_W = 1;
    localparam int DIF_W     = 34;   // coordinate differences
    localparam int OPA_W     = 68;   // multiplicand (holds partial blends)
    localparam int ACC_W     = 104;  // multiply accumulator
    localparam int NUM_W     = 100;  // |numerator|
    localparam int DEN_W     = 66;   // |denominator|
    localparam int DIV_W     = 102;  // divider remainder
    localparam int MB_W      = 36;   // multiplier magnitude, nibble aligned
    localparam int MUL_STEPS = 9;    // nibbles of MB_W
    localparam int MC_W      = 4;

    localparam logic [CFG_W-1:0] PTS_RESET = 5'd16;

    typedef enum logic [MODE_W-1:0] {
        MODE_WR_X    = 2'd0,
        MODE_WR_Y    = 2'd1,
        MODE_WR_GRID = 2'd2,
        MODE_QUERY   = 2'd3
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_X_USED = 1'b0,
        CFG_Y_USED = 1'b1
    } t_cfg_reg;

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_PICK, S_SETUP, S_GRID, S_MLOAD, S_MSTEP, S_MPOST,
        S_DIVPREP, S_DIVCHK, S_DIV, S_FIN, S_DONE
    } t_state;

    // multiply sequence: denominator, then two partial x blends, then y blend
    typedef enum logic [2:0] {
        OP_DEN, OP_F11, OP_F21, OP_F12, OP_F22, OP_S1, OP_S2
    } t_mul_op;

    typedef struct packed {
        logic signed [VAL_W-1:0] first;
        logic signed [VAL_W-1:0] a1;
        logic signed [VAL_W-1:0] pen;
        logic signed [VAL_W-1:0] last;
        logic signed [VAL_W-1:0] prev;
        logic signed [VAL_W-1:0] lo;
        logic signed [VAL_W-1:0] hi;
        logic                    found;
        logic [IDX_W-1:0]        fidx;
    } t_axis_scan;

    typedef struct packed {
        logic [IDX_W-1:0]        idx;
        logic signed [VAL_W-1:0] c;
        logic signed [VAL_W-1:0] lo;
        logic signed [VAL_W-1:0] hi;
    } t_axis_pick;

endpackage

FILE: rtl/core/bilinear_table_interp.sv
// Bilinear table interpolator: one query at a time, table in three sync RAMs.
// Query steps: axis scan one entry per cycle, four grid reads, seven nibble-serial
// multiplies, then one quotient bit per cycle; a zero-width cell skips the grid
// reads, the multiplies and the division. A new query is taken only back in idle;
// write items are accepted in idle and do not leave it.
// Sync active-low reset clears control, sets points-used to 16; table undefined.
module bilinear_table_interp
    import bti_pkg::*;
#(
    parameter int MAX_X_POINTS = 16,
    parameter int MAX_Y_POINTS = 16,
    parameter int VALUE_BITS   = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [MODE_W-1:0]       i_mode,
    input  logic [IDX_W-1:0]        i_entry_index,
    input  logic signed [VAL_W-1:0] i_entry_value,
    input  logic signed [VAL_W-1:0] i_query_x,
    input  logic signed [VAL_W-1:0] i_query_y,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic signed [VAL_W-1:0] o_result_value,
    output logic                    o_flat_interval,
    output logic                    o_saturated,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_W-1:0]        i_cfg_data
);

    localparam int XA_W     = $clog2(MAX_X_POINTS);
    localparam int YA_W     = $clog2(MAX_Y_POINTS);
    localparam int GD       = MAX_X_POINTS * MAX_Y_POINTS;
    localparam int GA_W     = $clog2(GD);
    localparam int NMAX     = (MAX_X_POINTS > MAX_Y_POINTS) ? MAX_X_POINTS : MAX_Y_POINTS;
    localparam int K_W      = $clog2(NMAX + 1);
    localparam int SAT_BITS = (VALUE_BITS > 32) ? 32 : VALUE_BITS;
    localparam int DC_W     = $clog2(SAT_BITS);
    localparam logic [VAL_W:0] NEG_MAX = (VAL_W+1)'(1) << (SAT_BITS - 1);
    localparam logic [VAL_W:0] POS_MAX = NEG_MAX - (VAL_W+1)'(1);

    // ---------------------------------------------------------------- helpers
    function automatic logic [K_W-1:0] f_used(logic [CFG_W-1:0] v, int max_pts);
        if (v < CFG_W'(2)) return K_W'(2);
        if (int'(v) > max_pts) return K_W'(max_pts);
        return K_W'(v);
    endfunction

    function automatic t_axis_scan f_scan(t_axis_scan s, logic [K_W-1:0] j,
                                          logic [K_W-1:0] n,
                                          logic signed [VAL_W-1:0] q,
                                          logic signed [VAL_W-1:0] d);
        t_axis_scan r;
        r = s;
        if (j == K_W'(0)) r.first = d;
        if (j == K_W'(1)) r.a1 = d;
        if (j == n - K_W'(2)) r.pen = d;
        if (j == n - K_W'(1)) r.last = d;
        if (j != K_W'(0) && !s.found && $signed(s.prev) <= q && q <= d) begin
            r.found = 1'b1;
            r.fidx  = IDX_W'(j - K_W'(1));
            r.lo    = s.prev;
            r.hi    = d;
        end
        r.prev = d;
        return r;
    endfunction

    function automatic t_axis_pick f_pick(t_axis_scan s, logic signed [VAL_W-1:0] q,
                                          logic [K_W-1:0] n);
        t_axis_pick p;
        p.idx = '0;
        p.c   = q;
        p.lo  = s.first;
        p.hi  = s.a1;
        if (q < $signed(s.first)) begin
            p.c = s.first;
        end else if (q > $signed(s.last)) begin
            p.idx = IDX_W'(n - K_W'(2));
            p.c   = s.last;
            p.lo  = s.pen;
            p.hi  = s.last;
        end else if (s.found) begin
            p.idx = s.fidx;
            p.lo  = s.lo;
            p.hi  = s.hi;
        end
        return p;
    endfunction

    // ---------------------------------------------------------------- state
    t_state  r_state, n_state;
    t_mul_op r_op;

    logic [CFG_W-1:0] r_x_used, r_y_used;
    logic [K_W-1:0]   r_nx, r_ny, r_nmax, r_k, r_kd;
    logic             r_dv;
    logic signed [VAL_W-1:0] r_xq, r_yq;
    t_axis_scan r_xs, r_ys;
    t_axis_pick r_xp, r_yp;

    logic signed [DIF_W-1:0] r_dx, r_dy, r_dxh, r_dxl, r_dyh, r_dyl;
    logic [GA_W-1:0]         r_gbase;
    logic [2:0]              r_gi;
    logic [1:0]              r_gd;
    logic                    r_gdv;
    logic signed [VAL_W-1:0] r_f [4];

    logic signed [ACC_W-1:0] r_acc, r_ma;
    logic [MB_W-1:0]         r_mb;
    logic [MC_W-1:0]         r_mc;
    logic signed [OPA_W-1:0] r_s1, r_s2;
    logic                    r_dneg, r_nneg;
    logic [DEN_W-1:0]        r_dmag;
    logic [NUM_W-1:0]        r_nmag;

    logic [DIV_W-1:0]    r_rem, r_d2, r_dsh;
    logic [SAT_BITS-1:0] r_q;
    logic [DC_W-1:0]     r_dc;
    logic                r_ovf;

    logic signed [VAL_W-1:0] r_res;
    logic                    r_rflat, r_rsat;
    logic                    r_ov;
    logic signed [VAL_W-1:0] r_o_val;
    logic                    r_o_flat, r_o_sat;

    // memories
    logic signed [VAL_W-1:0] x_mem [MAX_X_POINTS];
    logic signed [VAL_W-1:0] y_mem [MAX_Y_POINTS];
    logic signed [VAL_W-1:0] g_mem [GD];
    logic signed [VAL_W-1:0] r_xrd, r_yrd, r_grd;
    logic [GA_W-1:0]         g_raddr;

    // ---------------------------------------------------------------- comb
    logic in_acc, out_free, flat, ovf, is_query;
    logic signed [OPA_W-1:0] mul_a;
    logic signed [DIF_W-1:0] mul_b;
    logic [DIF_W-1:0]        b_abs;
    logic                    mul_clr;
    logic [ACC_W-1:0]        acc_abs;
    logic                    div_ge;
    logic [VAL_W:0]          q_ext, mag;
    logic                    fin_neg, fin_sat;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign is_query    = (t_mode'(i_mode) == MODE_QUERY);
    assign out_free    = !r_ov || !i_out_stall;
    assign flat        = (r_xp.lo == r_xp.hi) || (r_yp.lo == r_yp.hi);
    assign ovf         = r_rem >= (r_d2 << SAT_BITS);
    assign div_ge      = r_rem >= r_dsh;
    assign acc_abs     = r_acc[ACC_W-1] ? ACC_W'(-r_acc) : ACC_W'(r_acc);
    assign b_abs       = mul_b[DIF_W-1] ? DIF_W'(-mul_b) : DIF_W'(mul_b);

    always_comb begin
        mul_a   = OPA_W'(r_dx);
        mul_b   = r_dy;
        mul_clr = 1'b1;
        unique case (r_op)
            OP_DEN: begin mul_a = OPA_W'(r_dx);   mul_b = r_dy;  mul_clr = 1'b1; end
            OP_F11: begin mul_a = OPA_W'(r_f[0]); mul_b = r_dxh; mul_clr = 1'b1; end
            OP_F21: begin mul_a = OPA_W'(r_f[1]); mul_b = r_dxl; mul_clr = 1'b0; end
            OP_F12: begin mul_a = OPA_W'(r_f[2]); mul_b = r_dxh; mul_clr = 1'b1; end
            OP_F22: begin mul_a = OPA_W'(r_f[3]); mul_b = r_dxl; mul_clr = 1'b0; end
            OP_S1:  begin mul_a = r_s1;           mul_b = r_dyh; mul_clr = 1'b1; end
            OP_S2:  begin mul_a = r_s2;           mul_b = r_dyl; mul_clr = 1'b0; end
            default: ;
        endcase
    end

    // corner order: (ix,iy) (ix+1,iy) (ix,iy+1) (ix+1,iy+1)
    always_comb begin
        case (r_gi[1:0])
            2'd0:    g_raddr = r_gbase;
            2'd1:    g_raddr = r_gbase + GA_W'(MAX_Y_POINTS);
            2'd2:    g_raddr = r_gbase + GA_W'(1);
            default: g_raddr = r_gbase + GA_W'(MAX_Y_POINTS + 1);
        endcase
    end

    always_comb begin
        q_ext   = (VAL_W+1)'(r_q);
        fin_neg = r_nneg ^ r_dneg;
        fin_sat = r_ovf || (fin_neg ? (q_ext > NEG_MAX) : (q_ext > POS_MAX));
        mag     = fin_sat ? (fin_neg ? NEG_MAX : POS_MAX) : q_ext;
    end

    // ---------------------------------------------------------------- fsm
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:    if (in_acc && is_query) n_state = S_SCAN;
            S_SCAN:    if (r_dv && r_kd == r_nmax - K_W'(1)) n_state = S_PICK;
            S_PICK:    n_state = S_SETUP;
            S_SETUP:   n_state = flat ? S_DONE : S_GRID;
            S_GRID:    if (r_gdv && r_gd == 2'd3) n_state = S_MLOAD;
            S_MLOAD:   n_state = S_MSTEP;
            S_MSTEP:   if (r_mc == MC_W'(MUL_STEPS - 1)) n_state = S_MPOST;
            S_MPOST:   n_state = (r_op == OP_S2) ? S_DIVPREP : S_MLOAD;
            S_DIVPREP: n_state = S_DIVCHK;
            S_DIVCHK:  n_state = ovf ? S_FIN : S_DIV;
            S_DIV:     if (r_dc == DC_W'(SAT_BITS - 1)) n_state = S_FIN;
            S_FIN:     n_state = S_DONE;
            S_DONE:    if (out_free) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // ---------------------------------------------------------------- memories
    always_ff @(posedge i_clk) begin
        if (in_acc && t_mode'(i_mode) == MODE_WR_X && int'(i_entry_index) < MAX_X_POINTS)
            x_mem[XA_W'(i_entry_index)] <= i_entry_value;
        if (in_acc && t_mode'(i_mode) == MODE_WR_Y && int'(i_entry_index) < MAX_Y_POINTS)
            y_mem[YA_W'(i_entry_index)] <= i_entry_value;
        if (in_acc && t_mode'(i_mode) == MODE_WR_GRID && int'(i_entry_index) < GD)
            g_mem[GA_W'(i_entry_index)] <= i_entry_value;
        r_xrd <= x_mem[XA_W'(r_k)];
        r_yrd <= y_mem[YA_W'(r_k)];
        r_grd <= g_mem[g_raddr];
    end

    // ---------------------------------------------------------------- control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_used <= PTS_RESET;
            r_y_used <= PTS_RESET;
            r_dv     <= 1'b0;
            r_gdv    <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (t_cfg_reg'(i_cfg_index))
                    CFG_X_USED: r_x_used <= i_cfg_data;
                    CFG_Y_USED: r_y_used <= i_cfg_data;
                    default: ;
                endcase
            end
            r_dv  <= (r_state == S_SCAN) && (r_k < r_nmax);
            r_gdv <= (r_state == S_GRID) && (r_gi < 3'd4);
            if (r_state == S_DONE && out_free)
                r_ov <= 1'b1;
            else if (r_ov && !i_out_stall)
                r_ov <= 1'b0;
        end
    end

    // ---------------------------------------------------------------- datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_xq       <= i_query_x;
                r_yq       <= i_query_y;
                r_nx       <= f_used(r_x_used, MAX_X_POINTS);
                r_ny       <= f_used(r_y_used, MAX_Y_POINTS);
                r_nmax     <= (f_used(r_x_used, MAX_X_POINTS) > f_used(r_y_used, MAX_Y_POINTS))
                              ? f_used(r_x_used, MAX_X_POINTS)
                              : f_used(r_y_used, MAX_Y_POINTS);
                r_k        <= '0;
                r_xs.found <= 1'b0;
                r_ys.found <= 1'b0;
            end
            S_SCAN: begin
                if (r_k < r_nmax) r_k <= r_k + K_W'(1);
                r_kd <= r_k;
                if (r_dv && r_kd < r_nx) r_xs <= f_scan(r_xs, r_kd, r_nx, r_xq, r_xrd);
                if (r_dv && r_kd < r_ny) r_ys <= f_scan(r_ys, r_kd, r_ny, r_yq, r_yrd);
            end
            S_PICK: begin
                r_xp <= f_pick(r_xs, r_xq, r_nx);
                r_yp <= f_pick(r_ys, r_yq, r_ny);
            end
            S_SETUP: begin
                r_dx    <= DIF_W'($signed(r_xp.hi)) - DIF_W'($signed(r_xp.lo));
                r_dy    <= DIF_W'($signed(r_yp.hi)) - DIF_W'($signed(r_yp.lo));
                r_dxh   <= DIF_W'($signed(r_xp.hi)) - DIF_W'($signed(r_xp.c));
                r_dxl   <= DIF_W'($signed(r_xp.c))  - DIF_W'($signed(r_xp.lo));
                r_dyh   <= DIF_W'($signed(r_yp.hi)) - DIF_W'($signed(r_yp.c));
                r_dyl   <= DIF_W'($signed(r_yp.c))  - DIF_W'($signed(r_yp.lo));
                r_gbase <= GA_W'(int'(r_xp.idx) * MAX_Y_POINTS + int'(r_yp.idx));
                r_gi    <= '0;
                r_op    <= OP_DEN;
                r_res   <= '0;
                r_rflat <= 1'b1;
                r_rsat  <= 1'b0;
            end
            S_GRID: begin
                if (r_gi < 3'd4) r_gi <= r_gi + 3'd1;
                r_gd <= r_gi[1:0];
                if (r_gdv) r_f[r_gd] <= r_grd;
            end
            S_MLOAD: begin
                r_ma <= ACC_W'(mul_b[DIF_W-1] ? -mul_a : mul_a);
                r_mb <= MB_W'(b_abs);
                r_mc <= '0;
                if (mul_clr) r_acc <= '0;
            end
            S_MSTEP: begin
                r_acc <= r_acc + r_ma * $signed({1'b0, r_mb[3:0]});
                r_ma  <= r_ma <<< 4;
                r_mb  <= r_mb >> 4;
                r_mc  <= r_mc + MC_W'(1);
            end
            S_MPOST: begin
                case (r_op)
                    OP_DEN: begin
                        r_dneg <= r_acc[ACC_W-1];
                        r_dmag <= acc_abs[DEN_W-1:0];
                    end
                    OP_F21: r_s1 <= r_acc[OPA_W-1:0];
                    OP_F22: r_s2 <= r_acc[OPA_W-1:0];
                    OP_S2: begin
                        r_nneg <= r_acc[ACC_W-1];
                        r_nmag <= acc_abs[NUM_W-1:0];
                    end
                    default: ;
                endcase
                if (r_op != OP_S2) r_op <= t_mul_op'(r_op + 3'd1);
            end
            S_DIVPREP: begin
                // round half away: (2|N| + |D|) / (2|D|)
                r_rem <= DIV_W'({r_nmag, 1'b0}) + DIV_W'(r_dmag);
                r_d2  <= DIV_W'({r_dmag, 1'b0});
            end
            S_DIVCHK: begin
                r_ovf <= ovf;
                r_dsh <= r_d2 << (SAT_BITS - 1);
                r_q   <= '0;
                r_dc  <= '0;
            end
            S_DIV: begin
                if (div_ge) r_rem <= r_rem - r_dsh;
                r_q   <= {r_q[SAT_BITS-2:0], div_ge};
                r_dsh <= r_dsh >> 1;
                r_dc  <= r_dc + DC_W'(1);
            end
            S_FIN: begin
                r_res   <= VAL_W'(fin_neg ? ((VAL_W+1)'(0) - mag) : mag);
                r_rflat <= 1'b0;
                r_rsat  <= fin_sat;
            end
            S_DONE: begin
                if (out_free) begin
                    r_o_val  <= r_res;
                    r_o_flat <= r_rflat;
                    r_o_sat  <= r_rsat;
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid     = r_ov;
    assign o_result_value  = r_o_val;
    assign o_flat_interval = r_o_flat;
    assign o_saturated     = r_o_sat;

    // ---------------------------------------------------------------- checks
    a_write_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !is_query) |=> (r_state == S_IDLE))
        else $error("write word did not return to idle");

    a_query_scans: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && is_query) |=> (r_state == S_SCAN))
        else $error("query word did not start axis scan");

    a_div_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < (r_dsh << 1)))
        else $error("divider remainder out of range");

    a_flat_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_o_flat) |-> (r_o_val == '0 && !r_o_sat))
        else $error("flat interval result not zero");

    a_done_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_ov && i_out_stall) |=> (r_state == S_DONE))
        else $error("result dropped while output stalled");

endmodule
